[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CLGS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define CLGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLGS_ASSERT(lbl, expr)
`define CLGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/clgs_pkg.sv]
// ----------------------------------------------------------------------------
// Compressor/limiter gain stage package
// Widths, register map, microcode format and the microcode program.
// ----------------------------------------------------------------------------
package clgs_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COUNT_W    = 18;
  localparam int REL_W      = COUNT_W + 1;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 16;
  localparam int RATIO_W    = 17;
  localparam int THR_W      = SAMPLE_W - 1;
  localparam int TREC_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int O_W        = SAMPLE_W + 3;
  localparam int MB_W       = TREC_W + 1;
  localparam int PROD_W     = O_W + MB_W;

  localparam int MODE_LIMITER     = 0;
  localparam int MODE_AUTO_MAKEUP = 1;

  localparam logic [MODE_W-1:0]  RST_MODE        = '0;
  localparam logic [GAIN_W-1:0]  RST_INPUT_GAIN  = GAIN_W'(8192);
  localparam logic [COUNT_W-1:0] RST_ATTACK      = COUNT_W'(873);
  localparam logic [COUNT_W-1:0] RST_RELEASE     = COUNT_W'(4379);
  localparam logic [RATIO_W-1:0] RST_RATIO       = RATIO_W'(65536);
  localparam logic [THR_W-1:0]   RST_THRESHOLD   = {THR_W{1'b1}};
  localparam logic [TREC_W-1:0]  RST_THR_RECIP   = TREC_W'(65536);
  localparam logic [GAIN_W-1:0]  RST_OUTPUT_GAIN = GAIN_W'(8192);
  localparam logic [REL_W-1:0]   REL_MAX         = REL_W'(1) << COUNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_INPUT_GAIN,
    REG_ATTACK,
    REG_RELEASE,
    REG_RATIO,
    REG_THRESHOLD,
    REG_THR_RECIP,
    REG_OUTPUT_GAIN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_GAIN,
    STEP_DECIDE,
    STEP_RATIO,
    STEP_MAKEUP
  } step_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_GAIN,
    OP_RATIO,
    OP_MAKEUP
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_JUMP_PASS
  } cond_t;

  typedef struct packed {
    logic  wait_in;
    logic  decide;
    op_t   op;
    logic  emit;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t uc;
    case (pc)
      STEP_GAIN:   uc = '{wait_in: 1'b1, decide: 1'b0, op: OP_GAIN, emit: 1'b0,
                          cond: COND_NEXT, target: STEP_GAIN};
      STEP_DECIDE: uc = '{wait_in: 1'b0, decide: 1'b1, op: OP_NONE, emit: 1'b0,
                          cond: COND_JUMP_PASS, target: STEP_MAKEUP};
      STEP_RATIO:  uc = '{wait_in: 1'b0, decide: 1'b0, op: OP_RATIO, emit: 1'b0,
                          cond: COND_NEXT, target: STEP_GAIN};
      STEP_MAKEUP: uc = '{wait_in: 1'b0, decide: 1'b0, op: OP_MAKEUP, emit: 1'b1,
                          cond: COND_JUMP, target: STEP_GAIN};
      default:     uc = '{wait_in: 1'b0, decide: 1'b0, op: OP_NONE, emit: 1'b0,
                          cond: COND_JUMP, target: STEP_GAIN};
    endcase
    return uc;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [PROD_W-1:0] v
  );
    logic [PROD_W-SAMPLE_W:0] top;
    logic signed [SAMPLE_W-1:0] r;
    top = v[PROD_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/compressor_limiter_gain_stage.sv]
// ----------------------------------------------------------------------------
// Compressor/limiter gain stage
// Hard-knee compressor or limiter with input gain and makeup gain, run by a
// four-step microcode program over one shared multiplier.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     in_sample_in
//   out      output     out_valid / out_stall   out_sample_out
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item runs the gain, decide and makeup steps, with a ratio step before makeup
// when the compressor scales it; each step uses the single shared multiplier at most once.
// A new item is taken while the previous result waits in the output register.
// A stalled output holds the makeup step until the register frees up.
// Reset is synchronous and restores register defaults and clears both counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module compressor_limiter_gain_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [clgs_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [clgs_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [clgs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [clgs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import clgs_pkg::*;

  logic [MODE_W-1:0]  mode_r;
  logic [GAIN_W-1:0]  in_gain_r;
  logic [COUNT_W-1:0] attack_r;
  logic [COUNT_W-1:0] release_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [THR_W-1:0]   thr_r;
  logic [TREC_W-1:0]  thr_recip_r;
  logic [GAIN_W-1:0]  out_gain_r;

  step_t                      pc_r, pc_nxt;
  logic [COUNT_W-1:0]         att_r, att_nxt;
  logic [REL_W-1:0]           rel_r, rel_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [O_W-1:0]      o_r, o_nxt;
  logic signed [SAMPLE_W-1:0] out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  ucode_t                     uc;
  logic                       in_fire, out_free, emit_fire, step_hold, pass;
  logic                       over, compress;
  logic [SAMPLE_W-1:0]        mag, thr_ext, diff;
  logic signed [O_W-1:0]      thr_o, mag_c;
  logic signed [O_W-1:0]      mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod, prod_sh13, prod_sh16;

  assign uc        = ucode_rom(pc_r);
  assign in_stall  = !uc.wait_in;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = uc.emit && out_free;
  assign step_hold = (uc.wait_in && !in_fire) || (uc.emit && !out_free);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  assign mag     = x_r[SAMPLE_W-1] ? SAMPLE_W'(-x_r) : SAMPLE_W'(x_r);
  assign thr_ext = {1'b0, thr_r};
  assign thr_o   = $signed({{(O_W-THR_W){1'b0}}, thr_r});
  assign diff    = mag - thr_ext;
  assign over    = mag > thr_ext;

  always_comb begin
    case (uc.op)
      OP_GAIN: begin
        mul_a = O_W'(in_sample_in);
        mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, in_gain_r});
      end
      OP_RATIO: begin
        mul_a = $signed({{(O_W-SAMPLE_W){1'b0}}, diff});
        mul_b = $signed({{(MB_W-RATIO_W){1'b0}}, ratio_r});
      end
      OP_MAKEUP: begin
        mul_a = o_r;
        mul_b = mode_r[MODE_AUTO_MAKEUP] ? $signed({1'b0, thr_recip_r})
                                         : $signed({{(MB_W-GAIN_W){1'b0}}, out_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign prod_sh13 = prod >>> 13;
  assign prod_sh16 = prod >>> 16;
  assign mag_c     = O_W'(thr_ext) + prod_sh16[O_W-1:0];

  always_comb begin
    pc_nxt = pc_r;
    if (!step_hold) begin
      case (uc.cond)
        COND_NEXT:      pc_nxt = step_t'(pc_r + 1'b1);
        COND_JUMP:      pc_nxt = uc.target;
        COND_JUMP_PASS: pc_nxt = pass ? uc.target : step_t'(pc_r + 1'b1);
        default:        pc_nxt = STEP_GAIN;
      endcase
    end
  end

  always_comb begin
    att_nxt       = att_r;
    rel_nxt       = rel_r;
    x_nxt         = x_r;
    o_nxt         = o_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    compress      = rel_r != '0;
    pass          = 1'b1;

    if (in_fire) begin
      x_nxt = sat_sample(prod_sh13);
      if (att_r != '0) begin
        att_nxt = att_r - 1'b1;
      end
      if (rel_r != '0) begin
        rel_nxt = rel_r - 1'b1;
      end
    end

    if (uc.decide) begin
      if (mode_r[MODE_LIMITER]) begin
        if (mag < thr_ext) begin
          o_nxt = O_W'(x_r);
        end else if (x_r > 0) begin
          o_nxt = thr_o;
        end else begin
          o_nxt = -thr_o;
        end
      end else begin
        o_nxt = O_W'(x_r);
        pass  = !(compress && over);
        if (over) begin
          if (rel_r == '0 && att_r == '0) begin
            att_nxt = attack_r;
          end else if (att_r == '0) begin
            rel_nxt = {1'b0, release_r};
          end
        end
        if (att_nxt == COUNT_W'(1)) begin
          rel_nxt = {1'b0, release_r} + REL_W'(1);
        end
      end
    end

    if (uc.op == OP_RATIO) begin
      o_nxt = x_r[SAMPLE_W-1] ? -mag_c : mag_c;
    end

    if (emit_fire) begin
      out_nxt       = mode_r[MODE_AUTO_MAKEUP] ? sat_sample(prod_sh16)
                                               : sat_sample(prod_sh13);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_GAIN;
      att_r       <= '0;
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      att_r       <= att_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    o_r   <= o_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      in_gain_r   <= RST_INPUT_GAIN;
      attack_r    <= RST_ATTACK;
      release_r   <= RST_RELEASE;
      ratio_r     <= RST_RATIO;
      thr_r       <= RST_THRESHOLD;
      thr_recip_r <= RST_THR_RECIP;
      out_gain_r  <= RST_OUTPUT_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode_r      <= cfg_data[MODE_W-1:0];
        REG_INPUT_GAIN:  in_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_ATTACK:      attack_r    <= cfg_data[COUNT_W-1:0];
        REG_RELEASE:     release_r   <= cfg_data[COUNT_W-1:0];
        REG_RATIO:       ratio_r     <= cfg_data[RATIO_W-1:0];
        REG_THRESHOLD:   thr_r       <= cfg_data[THR_W-1:0];
        REG_THR_RECIP:   thr_recip_r <= cfg_data[TREC_W-1:0];
        REG_OUTPUT_GAIN: out_gain_r  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `CLGS_ASSERT_NEXT(a_accept_to_decide, in_valid && !in_stall, pc_r == STEP_DECIDE)
  `CLGS_ASSERT_NEXT(a_emit_fills_output, pc_r == STEP_MAKEUP && (!out_valid_r || !out_stall),
                    out_valid_r && pc_r == STEP_GAIN)
  `CLGS_ASSERT(a_release_in_range, rel_r <= REL_MAX)

endmodule
